// ----- sv/atpr_pkg.sv -----
// ----------------------------------------------------------------------------
// atpr_pkg: shared types and constants for the tilt angle block
// Widths, CORDIC angle table and the sqrt/CORDIC cell payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package atpr_pkg;
	localparam int AxisW  = 16;
	localparam int AngW   = 15;
	localparam int SqW    = 48;   // (a^2+b^2) << 16 fits in 48 bits
	localparam int RootW  = 24;   // isqrt of 48 bits
	localparam int CordW  = 28;   // x/y working width, grows by ~1.65
	localparam int ZW     = 34;
	localparam int TabLen = 24;
	localparam int Limit  = 9000;

	typedef logic signed [ZW-1:0] z_t;

	function automatic z_t atan_tab(input int i);
		z_t t;
		case (i)
			0: t = 34'sd294912000;  1: t = 34'sd174096719;
			2: t = 34'sd91987925;   3: t = 34'sd46694507;
			4: t = 34'sd23437865;   5: t = 34'sd11730358;
			6: t = 34'sd5866610;    7: t = 34'sd2933484;
			8: t = 34'sd1466764;    9: t = 34'sd733385;
			10: t = 34'sd366693;    11: t = 34'sd183346;
			12: t = 34'sd91673;     13: t = 34'sd45837;
			14: t = 34'sd22918;     15: t = 34'sd11459;
			16: t = 34'sd5730;      17: t = 34'sd2865;
			18: t = 34'sd1432;      19: t = 34'sd716;
			20: t = 34'sd358;       21: t = 34'sd179;
			22: t = 34'sd90;        23: t = 34'sd45;
			default: t = '0;
		endcase
		return t;
	endfunction

	// one lane of the square root chain; root is scaled by the current digit weight
	typedef struct packed {
		logic [SqW-1:0]          rem;
		logic [SqW-1:0]          root;
		logic signed [CordW-1:0] num;
	} sq_lane_t;

	// one lane of the CORDIC chain
	typedef struct packed {
		logic signed [CordW-1:0] x;
		logic signed [CordW-1:0] y;
		z_t                      z;
		logic                    zero;
	} cd_lane_t;
endpackage
`default_nettype wire

// ----- sv/atpr_if.sv -----
// ----------------------------------------------------------------------------
// atpr_if: valid/ready channel
// Generic handshake interface carrying a packed payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface atpr_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/accel_tilt_pitch_roll.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll: pitch and roll from one accelerometer triple
//
// Input channel in_ch carries {accel_x, accel_y, accel_z, read_ok}; output
// channel out_ch carries {pitch_angle, roll_angle} in 0.01 degree.
// A new item is taken in every cycle in which the chain is not stalled. The
// stages are input, squares, 24 square root digit cells, CORDIC cells and
// rounding, with the number of CORDIC cells, CORDIC_STAGES, capped at 24.
// The whole chain advances as one: when the
// output register holds an item that is not taken, the chain stops and
// in_ch.ready drops; a free output slot or empty chain lets it move.
// Reset clears all valid flags; payload registers are not reset.
// Both angles share each cell, one lane each.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_pitch_roll import atpr_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	atpr_if.sink     in_ch,
	atpr_if.source   out_ch
);
	localparam int NS   = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
	localparam int LAT  = 3 + RootW + NS;

	logic [LAT-1:0] vld_q;
	logic           en;
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[LAT-1];

	logic signed [AxisW-1:0] ax, ay, az;
	logic ok;
	assign {ax, ay, az, ok} = in_ch.data;

	logic signed [AxisW-1:0] ax_s1, ay_s1, az_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ok ? ax : '0;
			ay_s1 <= ok ? ay : '0;
			az_s1 <= ok ? az : '0;
		end
	end

	sq_lane_t sq_a [RootW+1];
	sq_lane_t sq_b [RootW+1];
	sq_lane_t sq_a_s2, sq_b_s2;
	logic signed [31:0] xx, yy, zz;
	assign xx = ax_s1 * ax_s1;
	assign yy = ay_s1 * ay_s1;
	assign zz = az_s1 * az_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_a_s2.rem  <= SqW'({(SqW-16)'(unsigned'(xx)) + (SqW-16)'(unsigned'(zz)), 16'h0});
			sq_a_s2.root <= '0;
			sq_a_s2.num  <= CordW'($signed({ay_s1, 8'h0}));
			sq_b_s2.rem  <= SqW'({(SqW-16)'(unsigned'(yy)) + (SqW-16)'(unsigned'(zz)), 16'h0});
			sq_b_s2.root <= '0;
			sq_b_s2.num  <= -CordW'($signed({ax_s1, 8'h0}));
		end
	end
	assign sq_a[0] = sq_a_s2;
	assign sq_b[0] = sq_b_s2;

	for (genvar k = 0; k < RootW; k++) begin : g_sq
		atpr_sqrt_cell #(.K(k)) u_cell (
			.clk(clk), .en(en), .in_a(sq_a[k]), .in_b(sq_b[k]),
			.out_a(sq_a[k+1]), .out_b(sq_b[k+1])
		);
	end

	cd_lane_t cd_a [NS+1];
	cd_lane_t cd_b [NS+1];

	function automatic cd_lane_t to_cd(input sq_lane_t l);
		cd_lane_t c;
		c.x    = CordW'(l.root);
		c.y    = l.num;
		c.z    = '0;
		c.zero = (l.root == '0) && (l.num == '0);
		return c;
	endfunction
	assign cd_a[0] = to_cd(sq_a[RootW]);
	assign cd_b[0] = to_cd(sq_b[RootW]);

	for (genvar i = 0; i < NS; i++) begin : g_cd
		atpr_cordic_cell #(.I(i)) u_cell (
			.clk(clk), .en(en), .in_a(cd_a[i]), .in_b(cd_b[i]),
			.out_a(cd_a[i+1]), .out_b(cd_b[i+1])
		);
	end

	function automatic logic signed [AngW-1:0] fin(input cd_lane_t l);
		z_t r;
		r = (l.z + z_t'(32768)) >>> 16;
		if (l.zero) r = '0;
		else if (r > z_t'(Limit)) r = z_t'(Limit);
		else if (r < -z_t'(Limit)) r = -z_t'(Limit);
		return AngW'(r);
	endfunction

	logic signed [AngW-1:0] pitch_q, roll_q;
	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= fin(cd_a[NS]);
			roll_q  <= fin(cd_b[NS]);
		end
	end
	assign out_ch.data = {pitch_q, roll_q};
endmodule
`default_nettype wire

// ----- sv/atpr_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// atpr_sqrt_cell: one digit of the integer square root
// Restoring digit-by-digit step for two lanes, registered when enabled.
// ----------------------------------------------------------------------------
`default_nettype none
module atpr_sqrt_cell import atpr_pkg::*; #(
	parameter int K = 0
) (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire sq_lane_t in_a,
	input  wire sq_lane_t in_b,
	output sq_lane_t      out_a,
	output sq_lane_t      out_b
);
	localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (RootW - 1 - K));

	function automatic sq_lane_t step(input sq_lane_t l);
		sq_lane_t o;
		logic [SqW-1:0] t;
		o = l;
		t = l.root + Bit;
		if (l.rem >= t) begin
			o.rem  = l.rem - t;
			o.root = (l.root >> 1) + Bit;
		end else begin
			o.root = l.root >> 1;
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_a <= step(in_a);
			out_b <= step(in_b);
		end
	end
endmodule
`default_nettype wire

// ----- sv/atpr_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// atpr_cordic_cell: one vectoring CORDIC rotation
// Rotates both lanes toward the x axis by atan(2^-I), registered when enabled.
// ----------------------------------------------------------------------------
`default_nettype none
module atpr_cordic_cell import atpr_pkg::*; #(
	parameter int I = 0
) (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire cd_lane_t in_a,
	input  wire cd_lane_t in_b,
	output cd_lane_t      out_a,
	output cd_lane_t      out_b
);
	localparam z_t T = atan_tab(I);

	function automatic cd_lane_t step(input cd_lane_t l);
		cd_lane_t o;
		o = l;
		if (!l.y[CordW-1]) begin
			o.x = l.x + (l.y >>> I);
			o.y = l.y - (l.x >>> I);
			o.z = l.z + T;
		end else begin
			o.x = l.x - (l.y >>> I);
			o.y = l.y + (l.x >>> I);
			o.z = l.z - T;
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_a <= step(in_a);
			out_b <= step(in_b);
		end
	end
endmodule
`default_nettype wire

// ----- sv/atpr_checker.sv -----
// ----------------------------------------------------------------------------
// atpr_checker: port-level checks for the tilt angle block
// Handshake and result range checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module atpr_checker import atpr_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic [2*AngW-1:0] out_data
);
	logic signed [AngW-1:0] p, r;
	assign {p, r} = out_data;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("ready low with free output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during stall");
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> p <= Limit && p >= -Limit && r <= Limit && r >= -Limit)
		else $error("angle out of range");
endmodule

bind accel_tilt_pitch_roll atpr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for accel_tilt_pitch_roll
// Feeds accelerometer triples through the input channel with random gaps,
// predicts pitch and roll with a bit-exact CORDIC model, and compares every
// output item in order. The output side stalls at random and holds off once
// for a long stretch so that the chain fills up and blocks its input.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import atpr_pkg::*;

	localparam int InW  = 3*AxisW + 1;
	localparam int OutW = 2*AngW;
	localparam int Stages = 16;
	localparam int Latency = 3 + 24 + Stages;
	localparam int CycleLimit = 200000;

	typedef struct packed {
		logic signed [AxisW-1:0] ax;
		logic signed [AxisW-1:0] ay;
		logic signed [AxisW-1:0] az;
		logic                    ok;
	} sample_t;

	typedef struct packed {
		logic signed [AngW-1:0] pitch;
		logic signed [AngW-1:0] roll;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	atpr_if #(.W(InW))  in_ch ();
	atpr_if #(.W(OutW)) out_ch ();

	accel_tilt_pitch_roll #(.CORDIC_STAGES(Stages)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	sample_t pending_q[$];
	tilt_t   tilt_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int cycle = 0;
	bit quiet = 1'b0;
	int holdoff = 0;
	bit held = 1'b0;
	bit in_took = 1'b0;

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic logic signed [AngW-1:0] tilt_angle(longint num, longint a, longint b);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		longint r;
		x = isqrt(longint'(a*a + b*b) << 16);
		y = num * 256;
		z = 0;
		if (x == 0 && y == 0) return '0;
		for (int i = 0; i < Stages && i < TabLen; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + longint'(atan_tab(i));
			end else begin
				x = x - ys; y = y + xs; z = z - longint'(atan_tab(i));
			end
		end
		r = asr(z + 32768, 16);
		if (r > Limit) r = Limit;
		if (r < -Limit) r = -Limit;
		return r[AngW-1:0];
	endfunction

	function automatic tilt_t predict_tilt(sample_t s);
		longint ax;
		longint ay;
		longint az;
		tilt_t t;
		ax = s.ok ? longint'(s.ax) : 0;
		ay = s.ok ? longint'(s.ay) : 0;
		az = s.ok ? longint'(s.az) : 0;
		t.pitch = tilt_angle(ay, ax, az);
		t.roll  = tilt_angle(-ax, ay, az);
		return t;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want, n_checked);
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		int k;
		k = $urandom_range(0, 9);
		s.ax = AxisW'($urandom);
		s.ay = AxisW'($urandom);
		s.az = AxisW'($urandom);
		if (k == 0) begin
			s.ax = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
			s.az = AxisW'(int'($urandom_range(0, 2)) - 1);
		end else if (k == 1) begin
			s.ax = AxisW'(int'($urandom_range(0, 64)) - 32);
			s.ay = AxisW'(int'($urandom_range(0, 64)) - 32);
			s.az = AxisW'(int'($urandom_range(0, 64)) - 32);
		end
		s.ok = ($urandom_range(0, 9) != 0);
		return s;
	endfunction

	function automatic sample_t mk(int x, int y, int z, bit ok);
		sample_t s;
		s.ax = AxisW'(x); s.ay = AxisW'(y); s.az = AxisW'(z); s.ok = ok;
		return s;
	endfunction

	// input acceptance, seen at the rising edge
	always @(posedge clk) begin
		in_took = 1'b0;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			in_took = 1'b1;
			tilt_q.push_back(predict_tilt(pending_q.pop_front()));
			n_sent++;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_took) begin
				// item still waiting, hold it
			end else if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_q[0];
			end else begin
				in_ch.valid <= 1'b0;
				in_ch.data  <= InW'($urandom);
			end
		end
	end

	// receiver ready with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (holdoff > 0) begin
				holdoff--;
				out_ch.ready <= 1'b0;
			end else if (!held && n_sent >= 100 && !quiet) begin
				held = 1'b1;
				holdoff = 3*Latency;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= quiet || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		tilt_t got;
		tilt_t want;
		cycle++;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (tilt_q.size() == 0) begin
				report("unexpected item", longint'(got), 0);
			end else begin
				want = tilt_q.pop_front();
				if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
				if (got.roll !== want.roll) report("roll", got.roll, want.roll);
			end
			n_checked++;
		end
		if (cycle > CycleLimit) begin
			$display("timeout at cycle %0d", cycle);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		pending_q.push_back(mk(0, 0, 0, 1));
		pending_q.push_back(mk(12345, -321, 999, 0));
		pending_q.push_back(mk(-32768, 0, 0, 1));
		pending_q.push_back(mk(32767, 0, 0, 1));
		pending_q.push_back(mk(0, -32768, 0, 1));
		pending_q.push_back(mk(0, 32767, 0, 1));
		pending_q.push_back(mk(0, 0, -32768, 1));
		pending_q.push_back(mk(0, 0, 32767, 1));
		pending_q.push_back(mk(-32768, -32768, -32768, 1));
		pending_q.push_back(mk(32767, 32767, 32767, 1));
		pending_q.push_back(mk(-32768, 32767, 0, 1));
		pending_q.push_back(mk(1, 0, 0, 1));
		pending_q.push_back(mk(-1, 1, 0, 1));
		pending_q.push_back(mk(0, 1, 1, 1));
		pending_q.push_back(mk(-1, -1, -1, 1));
		pending_q.push_back(mk(-32768, -32768, -32768, 0));
		pending_q.push_back(mk(16384, -16384, 16384, 1));
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		for (int i = 0; i < 200; i++) pending_q.push_back(rand_sample());
		wait (pending_q.size() == 0 && tilt_q.size() == 0);
		quiet = 1'b1;
		for (int i = 0; i < 150; i++) pending_q.push_back(rand_sample());
		wait (pending_q.size() == 0 && tilt_q.size() == 0);
		quiet = 1'b0;
		for (int i = 0; i < 250; i++) pending_q.push_back(rand_sample());
		wait (pending_q.size() == 0 && n_sent == 617);
		wait (tilt_q.size() == 0);
		repeat (2*Latency) @(posedge clk);
		$display("sent %0d items, checked %0d outputs, %0d mismatches", n_sent, n_checked, errors);
		$display("covered axis extremes, failed reads, zero vectors and back-pressure");
		if (errors == 0 && tilt_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
sv/atpr_pkg.sv
sv/atpr_if.sv
sv/atpr_sqrt_cell.sv
sv/atpr_cordic_cell.sv
sv/accel_tilt_pitch_roll.sv
sv/atpr_checker.sv
tb/tb.sv
